// ===== hw/rtl/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants for the stall reverse assist block.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int SPEED_W     = 17;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int IN_ITEM_W   = 20;
  localparam int RES_W       = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SPEED = 3'd0,
    REG_TARGET_MIN   = 3'd1,
    REG_TARGET_MAX   = 3'd2,
    REG_MOTION_THR   = 3'd3,
    REG_STALL_THR    = 3'd4,
    REG_MOTION_NEED  = 3'd5,
    REG_STALL_NEED   = 3'd6,
    REG_HOLD_TICKS   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] tgt_speed;
    logic signed [SPEED_W-1:0] target_min;
    logic signed [SPEED_W-1:0] target_max;
    logic [CFG_W-1:0]          motion_thr;
    logic [CFG_W-1:0]          stall_thr;
    logic [CFG_W-1:0]          motion_need;
    logic [CFG_W-1:0]          stall_need;
    logic [CFG_W-1:0]          hold_ticks;
  } cfg_t;

  // lowest bit first: mode_on, run_on, safe_ok, measured_speed
  typedef struct packed {
    logic signed [SPEED_W-1:0] measured_speed;
    logic                      safe_ok;
    logic                      run_on;
    logic                      mode_on;
  } in_item_t;

  // lowest bit first: active, speed_command
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_command;
    logic                      active;
  } res_t;

  localparam logic signed [SPEED_W-1:0] RST_TARGET_SPEED = 17'sd0;
  localparam logic signed [SPEED_W-1:0] RST_TARGET_MIN   = 17'sd0;
  localparam logic signed [SPEED_W-1:0] RST_TARGET_MAX   = 17'sd65535;
  localparam logic [CFG_W-1:0]          RST_MOTION_THR   = 16'd100;
  localparam logic [CFG_W-1:0]          RST_STALL_THR    = 16'd20;
  localparam logic [CFG_W-1:0]          RST_MOTION_NEED  = 16'd50;
  localparam logic [CFG_W-1:0]          RST_STALL_NEED   = 16'd10;
  localparam logic [CFG_W-1:0]          RST_HOLD_TICKS   = 16'd100;

  localparam logic signed [SPEED_W-1:0] SPEED_MOST_NEG = 17'sh10000;
  localparam logic signed [SPEED_W-1:0] SPEED_MOST_POS = 17'sd65535;

endpackage

// ===== hw/rtl/stall_reverse_assist_core.sv =====
// ----------------------------------------------------------------------------
// stall_reverse_assist_core
// Reverse assist for a bump-driving mode: one control tick in, one command out.
// ----------------------------------------------------------------------------
// Pipeline: 2 register stages (input, then result); out_tvalid rises as a
//   beat moves into the result register, one result beat per input beat.
// Throughput: 1 beat per cycle with out_tready high; counters update once
//   per tick in the single decision stage, so each tick sees the prior state.
// Reset: rst_n synchronous, active low; clears counters, pipeline valids and
//   loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module stall_reverse_assist_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [sra_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [sra_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input ticks
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] mode_on, [1] run_on, [2] safe_ok, [19:3] measured_speed, [23:20] zero
  input  logic [sra_pkg::IN_TDATA_W-1:0]     in_tdata,
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] active, [17:1] speed_command, [23:18] zero
  output logic [sra_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  sra_pkg::cfg_t     cfg;
  sra_pkg::in_item_t in_item_r;
  sra_pkg::res_t     res;
  sra_pkg::res_t     out_res_r;
  logic              in_v_r;
  logic              out_v_r;
  logic              adv;
  logic              step_en;

  // The result register is free when empty or being taken this cycle; the
  // input register then moves on and can take a fresh beat in the same cycle.
  assign adv       = !out_v_r || out_tready;
  assign step_en   = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  sra_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // decision stage: counters commit only when the tick moves into the
  // result register
  sra_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item_i  (in_item_r),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_tdata[sra_pkg::IN_ITEM_W-1:0];
    end
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(sra_pkg::OUT_TDATA_W - sra_pkg::RES_W){1'b0}}, out_res_r};

endmodule

// ===== hw/rtl/sra_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sra_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module sra_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sra_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [sra_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output sra_pkg::cfg_t                    cfg_o
);

  sra_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tgt_speed    <= sra_pkg::RST_TARGET_SPEED;
      cfg_r.target_min   <= sra_pkg::RST_TARGET_MIN;
      cfg_r.target_max   <= sra_pkg::RST_TARGET_MAX;
      cfg_r.motion_thr   <= sra_pkg::RST_MOTION_THR;
      cfg_r.stall_thr    <= sra_pkg::RST_STALL_THR;
      cfg_r.motion_need  <= sra_pkg::RST_MOTION_NEED;
      cfg_r.stall_need   <= sra_pkg::RST_STALL_NEED;
      cfg_r.hold_ticks   <= sra_pkg::RST_HOLD_TICKS;
    end else if (cfg_we) begin
      unique case (sra_pkg::cfg_idx_t'(cfg_addr))
        sra_pkg::REG_TARGET_SPEED: cfg_r.tgt_speed    <= $signed(cfg_wdata);
        sra_pkg::REG_TARGET_MIN:   cfg_r.target_min   <= $signed(cfg_wdata);
        sra_pkg::REG_TARGET_MAX:   cfg_r.target_max   <= $signed(cfg_wdata);
        sra_pkg::REG_MOTION_THR:   cfg_r.motion_thr   <= cfg_wdata[sra_pkg::CFG_W-1:0];
        sra_pkg::REG_STALL_THR:    cfg_r.stall_thr    <= cfg_wdata[sra_pkg::CFG_W-1:0];
        sra_pkg::REG_MOTION_NEED:  cfg_r.motion_need  <= cfg_wdata[sra_pkg::CFG_W-1:0];
        sra_pkg::REG_STALL_NEED:   cfg_r.stall_need   <= cfg_wdata[sra_pkg::CFG_W-1:0];
        sra_pkg::REG_HOLD_TICKS:   cfg_r.hold_ticks   <= cfg_wdata[sra_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== hw/rtl/sra_step.sv =====
// ----------------------------------------------------------------------------
// sra_step
// Per-tick decision logic and the motion/stall/hold counters.
// ----------------------------------------------------------------------------
module sra_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  sra_pkg::in_item_t item_i,
  input  sra_pkg::cfg_t     cfg_i,
  output sra_pkg::res_t     res_o
);

  localparam int CMPW = (COUNT_WIDTH > sra_pkg::CFG_W) ? COUNT_WIDTH : sra_pkg::CFG_W;

  logic [COUNT_WIDTH-1:0] moving_r, moving_nxt;
  logic [COUNT_WIDTH-1:0] stopped_r, stopped_nxt;
  logic [COUNT_WIDTH-1:0] rev_r, rev_nxt;

  logic signed [sra_pkg::SPEED_W-1:0] target;
  logic signed [sra_pkg::SPEED_W-1:0] target_neg;
  logic [sra_pkg::SPEED_W-1:0]        speed_mag;
  logic [COUNT_WIDTH-1:0]             cmax;
  logic [CMPW-1:0]                    cmax_ext;
  logic [sra_pkg::CFG_W-1:0]          hold16;
  logic [CMPW-1:0]                    hold_ext;
  logic [COUNT_WIDTH-1:0]             hold_clip;
  logic [COUNT_WIDTH-1:0]             stopped_inc;
  logic                               moving_fast;
  logic                               is_stopped;
  logic                               motion_done;

  always_comb begin
    // clamp: the lower bound is checked first, so when the bounds cross it wins only for a target below it
    if ($signed(cfg_i.tgt_speed) < $signed(cfg_i.target_min)) begin
      target = cfg_i.target_min;
    end else if ($signed(cfg_i.tgt_speed) > $signed(cfg_i.target_max)) begin
      target = cfg_i.target_max;
    end else begin
      target = cfg_i.tgt_speed;
    end

    target_neg = (target == sra_pkg::SPEED_MOST_NEG) ? sra_pkg::SPEED_MOST_POS : -target;

    // |speed| of the most negative code is 65536, still fits unsigned 17 bits
    speed_mag = item_i.measured_speed[sra_pkg::SPEED_W-1]
              ? -item_i.measured_speed
              : item_i.measured_speed;

    moving_fast = speed_mag > {1'b0, cfg_i.motion_thr};
    is_stopped  = speed_mag < {1'b0, cfg_i.stall_thr};

    cmax      = '1;
    cmax_ext  = CMPW'(cmax);
    hold16    = (cfg_i.hold_ticks == '0) ? sra_pkg::CFG_W'(1) : cfg_i.hold_ticks;
    hold_ext  = CMPW'(hold16);
    hold_clip = (hold_ext > cmax_ext) ? cmax : hold_ext[COUNT_WIDTH-1:0];

    motion_done = CMPW'(moving_r) >= CMPW'(cfg_i.motion_need);

    stopped_inc = stopped_r;
    if ((CMPW'(stopped_r) < CMPW'(cfg_i.stall_need)) && (stopped_r != cmax)) begin
      stopped_inc = stopped_r + COUNT_WIDTH'(1);
    end

    moving_nxt  = moving_r;
    stopped_nxt = stopped_r;
    rev_nxt     = rev_r;
    res_o.active        = 1'b1;
    res_o.speed_command = target;

    priority if (!item_i.mode_on || !item_i.run_on || !item_i.safe_ok) begin
      moving_nxt  = '0;
      stopped_nxt = '0;
      rev_nxt     = '0;
      res_o.active        = item_i.mode_on;
      res_o.speed_command = '0;
    end else if (rev_r != '0) begin
      rev_nxt             = rev_r - COUNT_WIDTH'(1);
      res_o.speed_command = target_neg;
    end else if (moving_fast) begin
      if (!motion_done && (moving_r != cmax)) begin
        moving_nxt = moving_r + COUNT_WIDTH'(1);
      end
      stopped_nxt = '0;
    end else if (is_stopped) begin
      if (motion_done) begin
        stopped_nxt = stopped_inc;
        if (CMPW'(stopped_inc) >= CMPW'(cfg_i.stall_need)) begin
          moving_nxt          = '0;
          stopped_nxt         = '0;
          rev_nxt             = hold_clip - COUNT_WIDTH'(1);
          res_o.speed_command = target_neg;
        end
      end
    end else begin
      // between the thresholds
      stopped_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r  <= '0;
      stopped_r <= '0;
      rev_r     <= '0;
    end else if (step_en) begin
      moving_r  <= moving_nxt;
      stopped_r <= stopped_nxt;
      rev_r     <= rev_nxt;
    end
  end

endmodule

// ===== bench/stall_reverse_assist_core_tb.sv =====
// ----------------------------------------------------------------------------
// stall_reverse_assist_core_tb
// Self-checking bench for the stall reverse assist core.
// A directed table covers reset defaults, the flag cases, clamp limits, the
// most negative target and a zero hold. Random phases follow with fresh
// register settings. Each phase drives move / stall / hold sequences with
// random content and some noise. Every result beat is checked against a
// cycle-free model of the command logic kept inside the bench.
// ----------------------------------------------------------------------------
module stall_reverse_assist_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sra_pkg::*;

  localparam int COUNT_W         = 16;
  localparam int COUNT_MAX       = (1 << COUNT_W) - 1;
  localparam int N_PHASES        = 8;
  localparam int PHASE_TICKS     = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 100;

  // speed classes for the stimulus, relative to the current thresholds
  typedef enum int {SPD_ANY, SPD_MOVING, SPD_STOPPED, SPD_BETWEEN} spd_kind_t;
  typedef enum int {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cfg_idx_t                idx;
    logic [CFG_DATA_W-1:0]   val;
    in_item_t                tick;
    bit                      pinned;   // result typed into the table
    res_t                    want;
  } dir_row_t;

  typedef struct {
    bit   pinned;
    res_t val;
  } pin_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_tvalid;
  logic                    in_tready;
  // [0] mode_on, [1] run_on, [2] safe_ok, [19:3] measured_speed, [23:20] zero
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  // [0] active, [17:1] speed_command, [23:18] zero
  logic [OUT_TDATA_W-1:0]  out_tdata;

  // model copy of the registers and the three counters
  cfg_t cfg_shadow;
  int   moving_ticks;
  int   stopped_ticks;
  int   hold_left;

  // pending commands, oldest first, and per-beat notes from the table
  res_t cmd_q[$];
  pin_t pin_q[$];

  int   ticks_sent;
  int   results_seen;
  int   mismatches;
  int   reversals;
  int   reversed_ticks;
  int   phases_run;

  // idling controls shared by both sides
  bit   steady;
  bit   hold_off_now;

  stall_reverse_assist_core #(
    .COUNT_WIDTH(COUNT_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d beats sent, %0d results seen", $time, ticks_sent,
             results_seen);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Command model
  // --------------------------------------------------------------------------

  // minus the target, with the one value that has no negative pinned at +max
  function automatic logic signed [SPEED_W-1:0] flip_speed(int v);
    if (v <= -65536) return SPEED_MOST_POS;
    return SPEED_W'(-v);
  endfunction

  function automatic res_t predict_command(in_item_t tick);
    res_t r;
    int   tgt, lo, hi, mag;
    int   mthr, sthr, mneed, sneed, hold;
    r     = '0;
    lo    = int'($signed(cfg_shadow.target_min));
    hi    = int'($signed(cfg_shadow.target_max));
    tgt   = int'($signed(cfg_shadow.tgt_speed));
    mthr  = int'(cfg_shadow.motion_thr);
    sthr  = int'(cfg_shadow.stall_thr);
    mneed = int'(cfg_shadow.motion_need);
    sneed = int'(cfg_shadow.stall_need);
    hold  = int'(cfg_shadow.hold_ticks);

    // any flag down: counters cleared, command zero; active follows mode alone
    if (!tick.mode_on || !tick.run_on || !tick.safe_ok) begin
      moving_ticks  = 0;
      stopped_ticks = 0;
      hold_left     = 0;
      r.active      = tick.mode_on;
      return r;
    end
    r.active = 1'b1;

    // lower bound checked first: when the bounds cross it wins only for a target below it
    if (tgt < lo) tgt = lo;
    else if (tgt > hi) tgt = hi;

    mag = int'($signed(tick.measured_speed));
    if (mag < 0) mag = -mag;

    // still inside a reversal: counters untouched
    if (hold_left > 0) begin
      hold_left--;
      reversed_ticks++;
      r.speed_command = flip_speed(tgt);
      return r;
    end

    if (mag > mthr) begin
      if (moving_ticks < mneed && moving_ticks < COUNT_MAX) moving_ticks++;
      stopped_ticks = 0;
    end else if (mag < sthr) begin
      if (moving_ticks >= mneed) begin
        if (stopped_ticks < sneed && stopped_ticks < COUNT_MAX) stopped_ticks++;
        if (stopped_ticks >= sneed) begin
          if (hold == 0) hold = 1;
          if (hold > COUNT_MAX) hold = COUNT_MAX;
          moving_ticks  = 0;
          stopped_ticks = 0;
          hold_left     = hold - 1;
          reversals++;
          r.speed_command = flip_speed(tgt);
          return r;
        end
      end
    end else begin
      // between the thresholds: stall run broken, motion kept
      stopped_ticks = 0;
    end

    r.speed_command = SPEED_W'(tgt);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Beat monitor: compare first, then record the new tick, so a result can
  // never be matched against the beat accepted on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    res_t got, want;
    pin_t pin;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        results_seen++;
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing pending: active %0b, speed_command %0d",
                     $time, got.active, $signed(got.speed_command));
        end else begin
          want = cmd_q.pop_front();
          if (got.active !== want.active) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: active mismatch: expected %0b, got %0b",
                       $time, want.active, got.active);
          end
          if (got.speed_command !== want.speed_command) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: speed_command mismatch: expected %0d, got %0d", $time,
                       $signed(want.speed_command), $signed(got.speed_command));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pin  = '{pinned: 1'b0, val: '0};
        if (pin_q.size() != 0) pin = pin_q.pop_front();
        want = predict_command(in_item_t'(in_tdata[IN_ITEM_W-1:0]));
        // a typed row overrides the model but the model state still advances
        if (pin.pinned) want = pin.val;
        cmd_q.push_back(want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: mostly ready, short stalls, now and then a long one. The
  // long hold-off is counted here so the input side keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  initial begin : sink
    int pick;
    forever begin
      if (hold_off_now) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_now = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else if (pick < 94) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (steady || hold_off_now) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays up across back-to-back beats; it only drops for a gap
  task automatic send_tick(in_item_t it, bit pinned, res_t want);
    pin_t p;
    int   gap;
    p.pinned = pinned;
    p.val    = want;
    gap      = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin_q.push_back(p);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-IN_ITEM_W){1'b0}}, it};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // drop valid, then wait for every result and let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_seen != ticks_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TARGET_SPEED: cfg_shadow.tgt_speed    = val;
      REG_TARGET_MIN:   cfg_shadow.target_min   = val;
      REG_TARGET_MAX:   cfg_shadow.target_max   = val;
      REG_MOTION_THR:   cfg_shadow.motion_thr   = val[CFG_W-1:0];
      REG_STALL_THR:    cfg_shadow.stall_thr    = val[CFG_W-1:0];
      REG_MOTION_NEED:  cfg_shadow.motion_need  = val[CFG_W-1:0];
      REG_STALL_NEED:   cfg_shadow.stall_need   = val[CFG_W-1:0];
      default:          cfg_shadow.hold_ticks   = val[CFG_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // whole register set; bit 16 of the 16-bit registers is junk the block drops
  task automatic load_config(int tgt, int lo, int hi, int mthr, int sthr,
                             int mneed, int sneed, int hold);
    settle();
    write_reg(REG_TARGET_SPEED, CFG_DATA_W'(tgt));
    write_reg(REG_TARGET_MIN,   CFG_DATA_W'(lo));
    write_reg(REG_TARGET_MAX,   CFG_DATA_W'(hi));
    write_reg(REG_MOTION_THR,   {1'($urandom_range(0, 1)), 16'(mthr)});
    write_reg(REG_STALL_THR,    {1'($urandom_range(0, 1)), 16'(sthr)});
    write_reg(REG_MOTION_NEED,  {1'($urandom_range(0, 1)), 16'(mneed)});
    write_reg(REG_STALL_NEED,   {1'($urandom_range(0, 1)), 16'(sneed)});
    write_reg(REG_HOLD_TICKS,   {1'($urandom_range(0, 1)), 16'(hold)});
    phases_run++;
  endtask

  // speed of the given class under the current thresholds, edges favoured
  function automatic logic signed [SPEED_W-1:0] pick_speed(spd_kind_t k);
    int lo, hi, mag, r;
    int mthr, sthr;
    mthr = int'(cfg_shadow.motion_thr);
    sthr = int'(cfg_shadow.stall_thr);
    lo   = 0;
    hi   = 65536;
    case (k)
      SPD_MOVING:  lo = mthr + 1;
      SPD_STOPPED: if (sthr > 0) hi = sthr - 1;
      SPD_BETWEEN: if (sthr <= mthr) begin
        lo = sthr;
        hi = mthr;
      end
      default: ;
    endcase
    r = $urandom_range(0, 99);
    if (r < 15) mag = lo;
    else if (r < 30) mag = hi;
    else mag = $urandom_range(hi, lo);
    // 65536 only exists as the most negative speed
    if (mag == 65536 || (mag != 0 && $urandom_range(0, 1) == 1)) mag = -mag;
    return SPEED_W'(mag);
  endfunction

  task automatic tick_of(spd_kind_t k, int noise_pct);
    in_item_t it;
    it.mode_on = 1'b1;
    it.run_on  = 1'b1;
    it.safe_ok = 1'b1;
    if ($urandom_range(0, 99) < noise_pct) begin
      it.mode_on = 1'($urandom_range(0, 1));
      it.run_on  = 1'($urandom_range(0, 1));
      it.safe_ok = 1'($urandom_range(0, 1));
    end
    it.measured_speed = pick_speed(k);
    send_tick(it, 1'b0, '0);
  endtask

  // move, stall and ride out the reversal for the needed counts (each capped at 40), some noise;
  // stall runs are now and then broken or skipped altogether
  task automatic run_episode();
    int n, mneed, sneed, hold;
    mneed = int'(cfg_shadow.motion_need);
    sneed = int'(cfg_shadow.stall_need);
    hold  = int'(cfg_shadow.hold_ticks);
    n = (mneed > 40 ? 40 : mneed) + $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) tick_of(SPD_BETWEEN, 2);
      else tick_of(SPD_MOVING, 2);
    end
    if ($urandom_range(0, 9) != 0) begin
      n = (sneed > 40 ? 40 : sneed) + $urandom_range(0, 2);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0) tick_of(SPD_ANY, 5);
        else tick_of(SPD_STOPPED, 1);
      end
    end
    n = (hold > 40 ? 40 : hold) + $urandom_range(0, 3);
    repeat (n) tick_of(SPD_ANY, 3);
    repeat ($urandom_range(0, 3)) tick_of(SPD_ANY, 40);
  endtask

  function automatic dir_row_t tick_row(bit m, bit r, bit s, int spd,
                                        bit pinned, bit act, int cmd);
    dir_row_t row;
    row.kind                = ROW_TICK;
    row.idx                 = REG_TARGET_SPEED;
    row.val                 = '0;
    row.tick.mode_on        = m;
    row.tick.run_on         = r;
    row.tick.safe_ok        = s;
    row.tick.measured_speed = SPEED_W'(spd);
    row.pinned              = pinned;
    row.want.active         = act;
    row.want.speed_command  = SPEED_W'(cmd);
    return row;
  endfunction

  function automatic dir_row_t reg_row(cfg_idx_t idx, int val);
    dir_row_t row;
    row        = tick_row(0, 0, 0, 0, 0, 0, 0);
    row.kind   = ROW_WRITE;
    row.idx    = idx;
    row.val    = CFG_DATA_W'(val);
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t dir_rows[$];
    int       phase_end, tgt, lo, hi, mthr, sthr, swap;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_wdata    <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    steady       = 1'b0;
    hold_off_now = 1'b0;
    cfg_shadow   = '{tgt_speed: RST_TARGET_SPEED, target_min: RST_TARGET_MIN,
                     target_max: RST_TARGET_MAX, motion_thr: RST_MOTION_THR,
                     stall_thr: RST_STALL_THR, motion_need: RST_MOTION_NEED,
                     stall_need: RST_STALL_NEED, hold_ticks: RST_HOLD_TICKS};

    // directed table: mode run safe speed | typed? active command
    // reset settings: target 0 already inside [0, 65535]
    dir_rows.push_back(tick_row(0, 1, 1, 0,      1, 0, 0));   // mode off
    dir_rows.push_back(tick_row(1, 0, 1, 65535,  1, 1, 0));   // run off
    dir_rows.push_back(tick_row(1, 1, 0, -65536, 1, 1, 0));   // safety off
    dir_rows.push_back(tick_row(1, 1, 1, 5,      1, 1, 0));
    // target above the upper bound; zero stall count and a zero hold
    dir_rows.push_back(reg_row(REG_TARGET_SPEED, 1000));
    dir_rows.push_back(reg_row(REG_TARGET_MIN, -500));
    dir_rows.push_back(reg_row(REG_TARGET_MAX, 800));
    dir_rows.push_back(reg_row(REG_MOTION_NEED, 2));
    dir_rows.push_back(reg_row(REG_STALL_NEED, 0));
    dir_rows.push_back(reg_row(REG_HOLD_TICKS, 0));
    dir_rows.push_back(tick_row(1, 1, 1, 101,    1, 1, 800));
    dir_rows.push_back(tick_row(1, 1, 1, -65536, 1, 1, 800));
    dir_rows.push_back(tick_row(1, 1, 1, 19,     1, 1, -800)); // reverses at once
    dir_rows.push_back(tick_row(1, 1, 1, 50,     0, 0, 0));
    // most negative target: its negation saturates
    dir_rows.push_back(reg_row(REG_TARGET_SPEED, -65536));
    dir_rows.push_back(reg_row(REG_TARGET_MIN, -65536));
    dir_rows.push_back(reg_row(REG_TARGET_MAX, 65535));
    dir_rows.push_back(reg_row(REG_MOTION_NEED, 0));
    dir_rows.push_back(reg_row(REG_STALL_NEED, 1));
    dir_rows.push_back(reg_row(REG_HOLD_TICKS, 2));
    dir_rows.push_back(tick_row(1, 1, 1, 0,      1, 1, 65535));
    dir_rows.push_back(tick_row(1, 1, 1, 65535,  1, 1, 65535));
    dir_rows.push_back(tick_row(1, 1, 1, 20,     1, 1, -65536));
    dir_rows.push_back(tick_row(1, 1, 1, 100,    0, 0, 0));
    // crossed bounds: lower bound wins; zero thresholds, counters at the top
    dir_rows.push_back(reg_row(REG_TARGET_SPEED, 300));
    dir_rows.push_back(reg_row(REG_TARGET_MIN, 500));
    dir_rows.push_back(reg_row(REG_TARGET_MAX, 200));
    dir_rows.push_back(reg_row(REG_MOTION_THR, 0));
    dir_rows.push_back(reg_row(REG_STALL_THR, 0));
    dir_rows.push_back(reg_row(REG_MOTION_NEED, 65535));
    dir_rows.push_back(reg_row(REG_STALL_NEED, 65535));
    dir_rows.push_back(reg_row(REG_HOLD_TICKS, 65535));
    dir_rows.push_back(tick_row(1, 1, 1, 0,      1, 1, 500));
    dir_rows.push_back(tick_row(1, 1, 1, 1,      1, 1, 500));
    dir_rows.push_back(tick_row(0, 0, 0, -1,     1, 0, 0));
    // thresholds at the top: only the most negative speed still moves
    dir_rows.push_back(reg_row(REG_MOTION_THR, 65535));
    dir_rows.push_back(reg_row(REG_STALL_THR, 65535));
    dir_rows.push_back(tick_row(1, 1, 1, -65536, 0, 0, 0));
    dir_rows.push_back(tick_row(1, 1, 1, 65535,  0, 0, 0));
    dir_rows.push_back(tick_row(1, 1, 1, -1,     0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_tick(dir_rows[i].tick, dir_rows[i].pinned, dir_rows[i].want);
      end
    end

    // random phases, each with its own register set
    for (int p = 0; p < N_PHASES; p++) begin
      tgt  = $urandom_range(0, 131071);
      lo   = $signed(17'($urandom_range(0, 131071)));
      hi   = $signed(17'($urandom_range(0, 131071)));
      // when the bounds cross, put them in order half the time
      if (lo > hi && $urandom_range(0, 1) == 1) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      mthr = $urandom_range(20, 4000);
      sthr = ($urandom_range(0, 9) == 0) ? $urandom_range(mthr, mthr + 500)
                                         : $urandom_range(0, mthr);
      phase_end = ticks_sent + PHASE_TICKS;
      case (p)
        1: load_config(-65536, -65536, 65535, 0, 65535, 1, 0, 3);
        4: begin
          // nothing stops and the counts can never be reached
          load_config(65535, -65536, 65535, 65535, 0, 65535, 65535, 65535);
          phase_end = ticks_sent + 60;
        end
        6: load_config(tgt, lo, hi, mthr, sthr, $urandom_range(0, 12),
                       $urandom_range(0, 8), 65535);
        default: load_config(tgt, lo, hi, mthr, sthr, $urandom_range(0, 12),
                             $urandom_range(0, 8), $urandom_range(0, 15));
      endcase
      steady       = (p == 5);
      hold_off_now = (p == 2);   // output held off while input keeps coming
      while (ticks_sent < phase_end) run_episode();
      steady = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk);
    if (cmd_q.size() != 0) begin
      mismatches += cmd_q.size();
      $display("%0t: %0d commands never came out", $time, cmd_q.size());
    end
    $display("Covered %0d ticks over %0d register sets, %0d results checked.",
             ticks_sent, phases_run, results_seen);
    $display("Reversals triggered: %0d, reversed hold ticks: %0d, mismatches: %0d.",
             reversals, reversed_ticks, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
